### rtl/bwts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bwts_pkg
// Shared types and constants of the bilinear wrap texture sampler.
// ----------------------------------------------------------------------------
package bwts_pkg;

  // Item opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam logic REG_TEX_WIDTH  = 1'b0;
  localparam logic REG_TEX_HEIGHT = 1'b1;

  // Widths fixed by the word format
  localparam int unsigned TEXEL_W = 16;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned CMP_W   = 13;  // holds sizes up to 8191

  // Texel memory control, shared by the four replicated memories
  typedef struct packed {
    logic               we;
    logic               re;
    logic [TEXEL_W-1:0] wdata;
  } mem_ctl_t;

  // Side information that travels with the texel read data
  typedef struct packed {
    logic        valid;
    logic        tex_ok;
    logic [15:0] tx;
    logic [15:0] ty;
  } lerp_ctl_t;

endpackage
`default_nettype wire

### rtl/bwts_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bwts_ram
// Single-port texel memory with registered read.
// ----------------------------------------------------------------------------
module bwts_ram #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               addr,
  input  wire logic [bwts_pkg::TEXEL_W-1:0] wdata,
  output logic      [bwts_pkg::TEXEL_W-1:0] rd_data
);

  logic [bwts_pkg::TEXEL_W-1:0] mem [DEPTH];
  logic [bwts_pkg::TEXEL_W-1:0] rd_data_r;

  // Write and read never fall in the same cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### rtl/bwts_addr_gen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bwts_addr_gen
// Wraps and scales u/v, finds the four neighbor texels and drives the
// texel memories. Writes go through the same stage as sample reads, so
// memory accesses stay in word order and never overlap.
// ----------------------------------------------------------------------------
module bwts_addr_gen #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned AW         = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic                        in_op,
  input  wire logic [7:0]                  in_texel_x,
  input  wire logic [7:0]                  in_texel_y,
  input  wire logic [15:0]                 in_texel_value,
  input  wire logic signed [31:0]          in_u_coord,
  input  wire logic signed [31:0]          in_v_coord,
  input  wire logic [bwts_pkg::SIZE_W-1:0] tex_width,
  input  wire logic [bwts_pkg::SIZE_W-1:0] tex_height,
  output bwts_pkg::mem_ctl_t               mem_ctl,
  output logic [3:0][AW-1:0]               mem_addr,
  output bwts_pkg::lerp_ctl_t              lerp_ctl
);

  localparam int unsigned AW1 = AW + 1;
  localparam logic [bwts_pkg::CMP_W-1:0] MAXW = bwts_pkg::CMP_W'(MAX_WIDTH);
  localparam logic [bwts_pkg::CMP_W-1:0] MAXH = bwts_pkg::CMP_W'(MAX_HEIGHT);

  // Row-major texel address
  function automatic logic [AW-1:0] tex_addr(input logic [8:0] x, input logic [8:0] y);
    logic [AW:0] full;
    full = AW1'(y) * AW1'(MAX_WIDTH) + AW1'(x);
    return full[AW-1:0];
  endfunction

  logic [8:0]  w_clamp, h_clamp;
  logic [24:0] fx_nxt, fy_nxt;
  logic        win_nxt;

  logic        s1_valid_r;
  logic        s1_op_r;
  logic        s1_ok_r;
  logic        s1_win_r;
  logic [24:0] s1_fx_r, s1_fy_r;
  logic [8:0]  s1_w_r, s1_h_r;
  logic [7:0]  s1_wx_r, s1_wy_r;
  logic [15:0] s1_wv_r;

  logic [8:0]  x0, y0, x1, y1, x0_inc, y0_inc;
  logic [AW-1:0] waddr;
  logic        is_write;

  bwts_pkg::lerp_ctl_t lerp_ctl_r;

  // Size clamp and scaling of the wrapped fraction
  assign w_clamp = ({4'b0, tex_width} > MAXW) ? MAXW[8:0] : tex_width;
  assign h_clamp = ({4'b0, tex_height} > MAXH) ? MAXH[8:0] : tex_height;
  assign fx_nxt  = 25'(in_u_coord[15:0]) * 25'(w_clamp);
  assign fy_nxt  = 25'(in_v_coord[15:0]) * 25'(h_clamp);
  assign win_nxt = ({5'b0, in_texel_x} < MAXW) && ({5'b0, in_texel_y} < MAXH);

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    s1_op_r  <= in_op;
    s1_ok_r  <= (w_clamp != 9'd0) && (h_clamp != 9'd0);
    s1_win_r <= win_nxt;
    s1_fx_r  <= fx_nxt;
    s1_fy_r  <= fy_nxt;
    s1_w_r   <= w_clamp;
    s1_h_r   <= h_clamp;
    s1_wx_r  <= in_texel_x;
    s1_wy_r  <= in_texel_y;
    s1_wv_r  <= in_texel_value;
  end

  // Base texel and wrapped neighbor
  assign x0     = s1_fx_r[24:16];
  assign y0     = s1_fy_r[24:16];
  assign x0_inc = x0 + 9'd1;
  assign y0_inc = y0 + 9'd1;
  assign x1     = (x0_inc == s1_w_r) ? 9'd0 : x0_inc;
  assign y1     = (y0_inc == s1_h_r) ? 9'd0 : y0_inc;

  // Memory port drive
  assign is_write      = s1_valid_r && (s1_op_r == bwts_pkg::OP_WRITE);
  assign waddr         = tex_addr({1'b0, s1_wx_r}, {1'b0, s1_wy_r});
  assign mem_ctl.we    = is_write && s1_win_r;
  assign mem_ctl.re    = s1_valid_r && (s1_op_r == bwts_pkg::OP_SAMPLE) && s1_ok_r;
  assign mem_ctl.wdata = s1_wv_r;
  assign mem_addr[0]   = is_write ? waddr : tex_addr(x0, y0);
  assign mem_addr[1]   = is_write ? waddr : tex_addr(x1, y0);
  assign mem_addr[2]   = is_write ? waddr : tex_addr(x0, y1);
  assign mem_addr[3]   = is_write ? waddr : tex_addr(x1, y1);

  // Side info aligned with the read data; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lerp_ctl_r.valid <= 1'b0;
    end else begin
      lerp_ctl_r.valid <= s1_valid_r && (s1_op_r == bwts_pkg::OP_SAMPLE);
    end
    lerp_ctl_r.tex_ok <= s1_ok_r;
    lerp_ctl_r.tx     <= s1_fx_r[15:0];
    lerp_ctl_r.ty     <= s1_fy_r[15:0];
  end

  assign lerp_ctl = lerp_ctl_r;

`ifndef SYNTH
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctl.we && mem_ctl.re))
    else $error("texel write and read in the same cycle");

  a_read_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.re |=> (lerp_ctl.valid && lerp_ctl.tex_ok))
    else $error("texel read without matching filter word");
`endif

endmodule
`default_nettype wire

### rtl/bwts_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bwts_filter
// Two row lerps, one column lerp, round to nearest and the output register.
// ----------------------------------------------------------------------------
module bwts_filter (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bwts_pkg::lerp_ctl_t  ctl,
  input  wire logic [15:0]          tex_a,
  input  wire logic [15:0]          tex_b,
  input  wire logic [15:0]          tex_c,
  input  wire logic [15:0]          tex_d,
  output logic                      out_valid,
  output logic [15:0]               out_sample_value
);

  localparam logic [48:0] RND_HALF = 49'h0_0000_8000_0000;

  logic signed [16:0] diff_ab, diff_cd, tx_s;
  logic signed [33:0] prod_ab, prod_cd, top_full, bot_full;

  logic        s3_valid_r, s3_ok_r;
  logic [15:0] s3_ty_r;
  logic [31:0] s3_top_r, s3_bot_r;

  logic signed [32:0] diff_tb;
  logic signed [16:0] ty_s;
  logic signed [49:0] prod_tb, acc_full;

  logic        s4_valid_r, s4_ok_r;
  logic [47:0] s4_acc_r;

  logic [48:0] rnd;
  logic [16:0] r17;
  logic [15:0] sat;

  logic        out_valid_r;
  logic [15:0] out_value_r;

  // Row lerps: top = a + (b - a) * tx, kept with 16 fraction bits
  assign diff_ab  = $signed({1'b0, tex_b}) - $signed({1'b0, tex_a});
  assign diff_cd  = $signed({1'b0, tex_d}) - $signed({1'b0, tex_c});
  assign tx_s     = $signed({1'b0, ctl.tx});
  assign prod_ab  = diff_ab * tx_s;
  assign prod_cd  = diff_cd * tx_s;
  assign top_full = $signed({2'b00, tex_a, 16'h0000}) + prod_ab;
  assign bot_full = $signed({2'b00, tex_c, 16'h0000}) + prod_cd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_ok_r  <= ctl.tex_ok;
    s3_ty_r  <= ctl.ty;
    s3_top_r <= top_full[31:0];
    s3_bot_r <= bot_full[31:0];
  end

  // Column lerp, 32 fraction bits; never negative
  assign diff_tb  = $signed({1'b0, s3_bot_r}) - $signed({1'b0, s3_top_r});
  assign ty_s     = $signed({1'b0, s3_ty_r});
  assign prod_tb  = diff_tb * ty_s;
  assign acc_full = $signed({2'b00, s3_top_r, 16'h0000}) + prod_tb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_ok_r  <= s3_ok_r;
    s4_acc_r <= acc_full[47:0];
  end

  // Round half up, saturate, zero for an invalid texture
  assign rnd = {1'b0, s4_acc_r} + RND_HALF;
  assign r17 = rnd[48:32];
  assign sat = r17[16] ? 16'hFFFF : r17[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= s4_ok_r ? sat : 16'h0000;
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;

endmodule
`default_nettype wire

### rtl/bilinear_wrap_texture_sampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_wrap_texture_sampler
// Single-channel mask texture with bilinear filtering and repeat wrapping.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken at each rising edge with start high and busy low; busy
//   is always low, so one word can be taken every cycle.
//   in_op = write stores in_texel_value at (in_texel_x, in_texel_y) and
//   gives no result. in_op = sample filters at Q16.16 (in_u_coord,
//   in_v_coord) and gives one result word.
//   A sample result appears on out_sample_value with out_valid high for one
//   cycle, after the address stage, the texel memory read, the row and
//   column lerp registers and the output register; results keep word order.
//   Throughput is one word per cycle: four replicated texel memories, each
//   written on every texel write inside the store, give all four neighbors in one read.
//   The receiver cannot stall; every result must be taken when shown.
//   tex_width / tex_height are written through cfg_we / cfg_index /
//   cfg_wdata while no sample is in flight; zero marks the texture invalid
//   and samples then return 0.
//   Reset clears the pipeline and both size registers; texel memory is not
//   cleared and must be written before it is sampled.
// ----------------------------------------------------------------------------
module bilinear_wrap_texture_sampler #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_op,
  input  wire logic [7:0]                  in_texel_x,
  input  wire logic [7:0]                  in_texel_y,
  input  wire logic [15:0]                 in_texel_value,
  input  wire logic signed [31:0]          in_u_coord,
  input  wire logic signed [31:0]          in_v_coord,
  output logic                             out_valid,
  output logic [15:0]                      out_sample_value,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [bwts_pkg::SIZE_W-1:0] cfg_wdata
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [bwts_pkg::SIZE_W-1:0] tex_width_r, tex_height_r;
  logic                        accept;

  bwts_pkg::mem_ctl_t  mem_ctl;
  bwts_pkg::lerp_ctl_t lerp_ctl;
  logic [3:0][AW-1:0]  mem_addr;
  logic [3:0][15:0]    tex_rd;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= '0;
      tex_height_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bwts_pkg::REG_TEX_WIDTH:  tex_width_r  <= cfg_wdata;
        bwts_pkg::REG_TEX_HEIGHT: tex_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Coordinate wrap, scale and address generation
  bwts_addr_gen #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_addr_gen (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_op          (in_op),
    .in_texel_x     (in_texel_x),
    .in_texel_y     (in_texel_y),
    .in_texel_value (in_texel_value),
    .in_u_coord     (in_u_coord),
    .in_v_coord     (in_v_coord),
    .tex_width      (tex_width_r),
    .tex_height     (tex_height_r),
    .mem_ctl        (mem_ctl),
    .mem_addr       (mem_addr),
    .lerp_ctl       (lerp_ctl)
  );

  // Four texel copies: a, b, c, d neighbors
  for (genvar g = 0; g < 4; g++) begin : g_ram
    bwts_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
    ) u_ram (
      .clk     (clk),
      .we      (mem_ctl.we),
      .re      (mem_ctl.re),
      .addr    (mem_addr[g]),
      .wdata   (mem_ctl.wdata),
      .rd_data (tex_rd[g])
    );
  end

  // Interpolation and output register
  bwts_filter u_filter (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (lerp_ctl),
    .tex_a            (tex_rd[0]),
    .tex_b            (tex_rd[1]),
    .tex_c            (tex_rd[2]),
    .tex_d            (tex_rd[3]),
    .out_valid        (out_valid),
    .out_sample_value (out_sample_value)
  );

`ifndef SYNTH
  a_sample_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == bwts_pkg::OP_SAMPLE)) |-> ##5 out_valid)
    else $error("sample word produced no result");

  a_result_has_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept && (in_op == bwts_pkg::OP_SAMPLE), 5))
    else $error("result without a sample word");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == bwts_pkg::OP_WRITE)) |-> ##5 !out_valid)
    else $error("texel write produced a result");
`endif

endmodule
`default_nettype wire

### dv/tb_bilinear_wrap_texture_sampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_bilinear_wrap_texture_sampler
// Self-checking bench for the bilinear wrap texture sampler. A short table
// of directed words covers invalid sizes, clamped sizes, edge wrap and
// extreme coordinates. Random phases follow, each with its own texture
// size. Every sample word is checked against a bit-exact bilinear filter
// kept in the bench, or against a value typed into the table. Texels are
// always written before any sample can read them.
// ----------------------------------------------------------------------------
module tb_bilinear_wrap_texture_sampler;

  localparam int unsigned MAX_W      = 256;
  localparam int unsigned MAX_H      = 256;
  localparam int unsigned DRAIN_WAIT = 8;    // pipeline is five deep
  localparam int unsigned PLAN_LEN   = 20;
  localparam int unsigned PHASES     = 14;
  localparam int unsigned PHASE_LEN  = 50;
  localparam int unsigned SZ_W       = bwts_pkg::SIZE_W;
  localparam logic        OP_WR      = bwts_pkg::OP_WRITE;
  localparam logic        OP_SM      = bwts_pkg::OP_SAMPLE;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_op;
  logic [7:0]          in_texel_x;
  logic [7:0]          in_texel_y;
  logic [15:0]         in_texel_value;
  logic signed [31:0]  in_u_coord;
  logic signed [31:0]  in_v_coord;
  logic                out_valid;
  logic [15:0]         out_sample_value;
  logic                cfg_we;
  logic                cfg_index;
  logic [SZ_W-1:0]     cfg_wdata;

  bilinear_wrap_texture_sampler #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_texel_x      (in_texel_x),
    .in_texel_y      (in_texel_y),
    .in_texel_value  (in_texel_value),
    .in_u_coord      (in_u_coord),
    .in_v_coord      (in_v_coord),
    .out_valid       (out_valid),
    .out_sample_value(out_sample_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Bench copy of the texture and the size registers
  logic [15:0]       texel_mem  [MAX_W*MAX_H];
  bit                texel_seen [MAX_W*MAX_H];
  logic [SZ_W-1:0]   width_reg;
  logic [SZ_W-1:0]   height_reg;
  logic [15:0]       filtered_q [$];
  int unsigned       errors;
  bit                burst_mode;

  // Directed words
  typedef struct {
    int unsigned w;
    int unsigned h;
    logic        op;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] val;
    logic [31:0] u;
    logic [31:0] v;
    bit          pinned;   // expected value typed in below
    logic [15:0] pin_val;
  } probe_t;

  probe_t plan [PLAN_LEN] = '{
    // invalid texture, reset sizes
    '{0,   0,   OP_SM, 8'h00, 8'h00, 16'h0000, 32'h00000000, 32'h00000000, 1, 16'h0000},
    '{0,   0,   OP_SM, 8'h00, 8'h00, 16'h0000, 32'h7FFFFFFF, 32'h80000000, 1, 16'h0000},
    '{256, 0,   OP_SM, 8'h00, 8'h00, 16'h0000, 32'h12345678, 32'hFFFFFFFF, 1, 16'h0000},
    '{0,   256, OP_SM, 8'h00, 8'h00, 16'h0000, 32'h0000FFFF, 32'h00008000, 1, 16'h0000},
    // 1x1 texture: every neighbor is the same texel
    '{1,   1,   OP_WR, 8'h00, 8'h00, 16'hFFFF, 32'h00000000, 32'h00000000, 0, 16'h0000},
    '{1,   1,   OP_SM, 8'h00, 8'h00, 16'h0000, 32'h89ABCDEF, 32'hFFFF0001, 1, 16'hFFFF},
    '{1,   1,   OP_WR, 8'h00, 8'h00, 16'h0000, 32'h00000000, 32'h00000000, 0, 16'h0000},
    '{1,   1,   OP_SM, 8'h00, 8'h00, 16'h0000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 16'h0000},
    // sizes above the store clamp to 256; max fraction wraps to column 0
    '{511, 511, OP_WR, 8'hFF, 8'hFF, 16'hFFFF, 32'h00000000, 32'h00000000, 0, 16'h0000},
    '{511, 511, OP_WR, 8'h00, 8'h00, 16'h0000, 32'h00000000, 32'h00000000, 0, 16'h0000},
    '{511, 511, OP_SM, 8'h00, 8'h00, 16'h0000, 32'h0000FFFF, 32'h0000FFFF, 0, 16'h0000},
    '{256, 256, OP_SM, 8'h00, 8'h00, 16'h0000, 32'h80000000, 32'h7FFFFFFF, 0, 16'h0000},
    '{256, 256, OP_WR, 8'hAA, 8'h55, 16'hA5A5, 32'h00000000, 32'h00000000, 0, 16'h0000},
    '{256, 256, OP_WR, 8'h55, 8'hAA, 16'h5A5A, 32'h00000000, 32'h00000000, 0, 16'h0000},
    '{256, 256, OP_SM, 8'h00, 8'h00, 16'h0000, 32'hFFFFAA80, 32'h00015580, 0, 16'h0000},
    // odd sizes, negative coordinate, whole-number coordinate
    '{3,   5,   OP_SM, 8'h00, 8'h00, 16'h0000, 32'hFFFF8000, 32'h00010000, 0, 16'h0000},
    '{256, 1,   OP_SM, 8'h00, 8'h00, 16'h0000, 32'h00000001, 32'hDEADBEEF, 0, 16'h0000},
    '{1,   256, OP_SM, 8'h00, 8'h00, 16'h0000, 32'hCAFEF00D, 32'hFFFFFFFF, 0, 16'h0000},
    '{2,   2,   OP_SM, 8'h00, 8'h00, 16'h0000, 32'h00004000, 32'h0000C000, 0, 16'h0000},
    // half coordinates on both axes scale to the whole texel (1, 1)
    '{2,   2,   OP_SM, 8'h00, 8'h00, 16'h0000, 32'h00008000, 32'h00008000, 0, 16'h0000}
  };

  // Size in use: values above the store clamp to it
  function automatic int unsigned used_size(input logic [SZ_W-1:0] s,
                                            input int unsigned cap);
    return (s > cap) ? cap : 32'(s);
  endfunction

  // Wrapped fraction scaled by the size: base index, wrapped neighbor, weight
  function automatic void axis_map(input logic [15:0] frac, input int unsigned size,
                                   output int unsigned base, output int unsigned nxt,
                                   output int unsigned wt);
    int unsigned f;
    f    = 32'(frac) * size;
    base = f >> 16;
    if (base >= size) base = size - 1;
    nxt  = (base + 1 == size) ? 0 : base + 1;
    wt   = f & 32'h0000FFFF;
  endfunction

  // Bilinear filter, exact intermediates, rounded half up to 16 bits
  function automatic logic [15:0] bilinear_filter(input logic [31:0] u, input logic [31:0] v);
    int unsigned w, h, x0, x1, y0, y1, wx, wy;
    longint      a, b, c, d, tx, ty, top, bot, acc, rnd;
    w = used_size(width_reg, MAX_W);
    h = used_size(height_reg, MAX_H);
    if (w == 0 || h == 0) return 16'h0000;
    axis_map(u[15:0], w, x0, x1, wx);
    axis_map(v[15:0], h, y0, y1, wy);
    tx  = wx;
    ty  = wy;
    a   = 64'(texel_mem[y0*MAX_W + x0]);
    b   = 64'(texel_mem[y0*MAX_W + x1]);
    c   = 64'(texel_mem[y1*MAX_W + x0]);
    d   = 64'(texel_mem[y1*MAX_W + x1]);
    top = a * 65536 + (b - a) * tx;
    bot = c * 65536 + (d - c) * tx;
    acc = top * 65536 + (bot - top) * ty;
    if (acc < 0) acc = 0;
    rnd = (acc + (longint'(1) <<< 31)) >>> 32;
    if (rnd > 65535) rnd = 65535;
    return rnd[15:0];
  endfunction

  task automatic flag_mismatch(input string what);
    errors++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic int unsigned draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 5);
  endfunction

  // Drive one word and wait for it to be taken; returns on the taking edge
  task automatic send_word(input logic op, input logic [7:0] x, input logic [7:0] y,
                           input logic [15:0] val, input logic [31:0] u,
                           input logic [31:0] v, input bit pinned,
                           input logic [15:0] pin_val);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_op          <= op;
    in_texel_x     <= x;
    in_texel_y     <= y;
    in_texel_value <= val;
    in_u_coord     <= u;
    in_v_coord     <= v;
    @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    @(posedge clk);
    if (op == OP_WR) begin
      texel_mem[y*MAX_W + x]  = val;
      texel_seen[y*MAX_W + x] = 1'b1;
    end else begin
      filtered_q.push_back(pinned ? pin_val : bilinear_filter(u, v));
    end
  endtask

  task automatic put_texel(input logic [7:0] x, input logic [7:0] y, input logic [15:0] val);
    send_word(OP_WR, x, y, val, $urandom, $urandom, 1'b0, 16'h0000);
  endtask

  // Sample word; any neighbor not yet written gets a random texel first
  task automatic take_sample(input logic [31:0] u, input logic [31:0] v,
                             input bit pinned, input logic [15:0] pin_val);
    int unsigned w, h, x0, x1, y0, y1, wx, wy;
    int unsigned xs [2];
    int unsigned ys [2];
    w = used_size(width_reg, MAX_W);
    h = used_size(height_reg, MAX_H);
    if (w != 0 && h != 0) begin
      axis_map(u[15:0], w, x0, x1, wx);
      axis_map(v[15:0], h, y0, y1, wy);
      xs = '{x0, x1};
      ys = '{y0, y1};
      foreach (ys[j]) begin
        foreach (xs[i]) begin
          if (!texel_seen[ys[j]*MAX_W + xs[i]])
            put_texel(8'(xs[i]), 8'(ys[j]), 16'($urandom));
        end
      end
    end
    send_word(OP_SM, 8'($urandom), 8'($urandom), 16'($urandom), u, v, pinned, pin_val);
  endtask

  // Hold off until every sample is back, then let the pipeline empty
  task automatic settle();
    start <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write both size registers; only called with the block idle
  task automatic set_size(input int unsigned w, input int unsigned h);
    cfg_we    <= 1'b1;
    cfg_index <= bwts_pkg::REG_TEX_WIDTH;
    cfg_wdata <= w[SZ_W-1:0];
    @(posedge clk);
    cfg_index <= bwts_pkg::REG_TEX_HEIGHT;
    cfg_wdata <= h[SZ_W-1:0];
    @(posedge clk);
    cfg_we     <= 1'b0;
    width_reg  = w[SZ_W-1:0];
    height_reg = h[SZ_W-1:0];
  endtask

  // Mostly small sizes, with the extremes and clamped values mixed in
  function automatic int unsigned pick_size();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return 256;
      3:       return 511;
      4:       return $urandom_range(0, 511);
      5, 6:    return $urandom_range(1, 16);
      default: return $urandom_range(2, 256);
    endcase
  endfunction

  // Coordinates: fully random, or just past / just short of a whole number
  function automatic logic [31:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      2:       r[15:0] = 16'($urandom_range(0, 15));
      3:       r[15:0] = 16'hFFFF - 16'($urandom_range(0, 15));
      default: ;
    endcase
    return r;
  endfunction

  // Result check, sampled mid-cycle so edge ordering does not matter
  always @(negedge clk) begin
    logic [15:0] want;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) begin
        if (filtered_q.size() == 0) begin
          flag_mismatch($sformatf("result %h with no sample pending", out_sample_value));
        end else begin
          want = filtered_q.pop_front();
          if (out_sample_value !== want)
            flag_mismatch($sformatf("sample_value %h, expected %h", out_sample_value, want));
        end
      end else if (out_valid !== 1'b0) begin
        flag_mismatch("out_valid unknown");
      end
    end
  end

  // Main sequence
  initial begin
    int unsigned r, w, h;
    errors         = 0;
    burst_mode     = 1'b0;
    width_reg      = '0;
    height_reg     = '0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_op          = OP_WR;
    in_texel_x     = '0;
    in_texel_y     = '0;
    in_texel_value = '0;
    in_u_coord     = '0;
    in_v_coord     = '0;
    cfg_we         = 1'b0;
    cfg_index      = bwts_pkg::REG_TEX_WIDTH;
    cfg_wdata      = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (plan[k]) begin
      if (plan[k].w[SZ_W-1:0] != width_reg || plan[k].h[SZ_W-1:0] != height_reg) begin
        settle();
        set_size(plan[k].w, plan[k].h);
      end
      if (plan[k].op == OP_WR)
        put_texel(plan[k].x, plan[k].y, plan[k].val);
      else
        take_sample(plan[k].u, plan[k].v, plan[k].pinned, plan[k].pin_val);
    end

    // Random phases, one texture size each
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       set_size(256, 256);
        1:       set_size(511, 0);
        2:       set_size(1, 511);
        default: set_size(pick_size(), pick_size());
      endcase
      burst_mode = ($urandom_range(0, 3) == 0);
      w = used_size(width_reg, MAX_W);
      h = used_size(height_reg, MAX_H);
      for (int n = 0; n < PHASE_LEN; n++) begin
        r = $urandom_range(0, 99);
        if (r < 2) settle();
        if (r < 60)
          take_sample(rand_coord(), rand_coord(), 1'b0, 16'h0000);
        else if (r < 85 && w != 0 && h != 0)
          put_texel(8'($urandom_range(0, w - 1)), 8'($urandom_range(0, h - 1)),
                    16'($urandom));
        else
          put_texel(8'($urandom), 8'($urandom), 16'($urandom));
      end
    end

    settle();
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Run limit
  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire
